// File: hw/rtl/rtpg_pkg.sv
// ----------------------------------------------------------------------------
// rtpg_pkg
// Shared types, constants and helpers of the raster test pattern generator.
// ----------------------------------------------------------------------------
package rtpg_pkg;

  localparam int MAX_DIM      = 4096;
  localparam int MAX_CHANNELS = 4;
  localparam int DIM_W        = 13;   // holds 1..MAX_DIM
  localparam int POS_W        = 12;   // holds 0..MAX_DIM-1
  localparam int CNT_W        = 3;    // holds 1..MAX_CHANNELS
  localparam int CH_W         = 2;    // channel index
  localparam int NUM_W        = 20;   // gradient numerator, below (MAX_DIM-1)*256
  localparam int STEP_W       = 4;    // divider step counter
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // pattern codes
  localparam logic [1:0] KIND_SOLID = 2'd0;
  localparam logic [1:0] KIND_GRAD  = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NCH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLORA = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLORB = 3'd6;

  // configuration as seen by the back end, already clamped
  typedef struct packed {
    logic [1:0]       kind;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [CNT_W-1:0] nch;
    logic [DIM_W-1:0] tile;
    logic [31:0]      color_a;
    logic [31:0]      color_b;
  } rtpg_cfg_t;

  // raster position of one pixel, front to back
  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             eol;
    logic             eof;
  } rtpg_pos_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_A,
    BK_MUL_B,
    BK_DIV,
    BK_TILE,
    BK_EMIT
  } rtpg_bk_state_t;

  function automatic logic [7:0] byte_of(input logic [31:0] color,
                                         input logic [CH_W-1:0] ch);
    logic [31:0] sh;
    sh = color >> {ch, 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/raster_test_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// raster_test_pattern_generator_unit
// Raster test pattern source: solid, vertical gradient and checkerboard.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the in_ stream asks for one pixel; in_tdata[0] set
//   restarts the raster at column 0, row 0 before that pixel. The out_ stream
//   returns the pixel: four channel bytes, column and row in out_tdata,
//   end of line on out_tlast and end of frame on out_tuser.
//   Registers are written through cfg_we/cfg_index/cfg_wdata while no
//   pixel is in flight.
// Processing:
//   A request is queued in a two-entry queue between the front and back
//   ends and worked on by the back end one at a time. Solid fill goes
//   straight to the emit state, checkerboard runs a 12-step serial divide
//   of column and row by the tile edge, gradient runs two multiply states
//   and an 8-step divide per channel (a one-row frame goes as solid fill).
//   In solid mode a pixel passes the queue, the idle and emit states.
// Reset and stalls:
//   rst_n clears the raster position, the queue, the output valid flag and
//   loads the register defaults. While out_tready is low the pixel holds in
//   the output register, the back end waits and the queue fills, after which
//   in_tready drops.
// ----------------------------------------------------------------------------
module raster_test_pattern_generator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] restart_frame
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] chan0, [15:8] chan1, [23:16] chan2, [31:24] chan3,
  // [43:32] pixel_col, [55:44] pixel_row
  output logic [55:0]                       out_tdata,
  output logic                              out_tlast,  // end_of_line
  output logic [0:0]                        out_tuser   // [0] end_of_frame
);
  import rtpg_pkg::*;

  rtpg_cfg_t cfg;
  rtpg_pos_t push_data, pop_data;
  logic      q_push, q_pop, q_full, q_empty;
  logic      eof_bit;

  rtpg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data),
    .cfg        (cfg)
  );

  rtpg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rtpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (eof_bit)
  );

  assign out_tuser = eof_bit;

endmodule

// File: hw/rtl/rtpg_fifo.sv
// ----------------------------------------------------------------------------
// rtpg_fifo
// Two-entry queue of raster positions between the front and back ends.
// ----------------------------------------------------------------------------
module rtpg_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtpg_pkg::rtpg_pos_t push_data,
  input  logic              pop,
  output rtpg_pkg::rtpg_pos_t pop_data,
  output logic              full,
  output logic              empty
);
  import rtpg_pkg::*;

  rtpg_pos_t  mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("rtpg_fifo: count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("rtpg_fifo: push into full queue");

endmodule

// File: hw/rtl/rtpg_front.sv
// ----------------------------------------------------------------------------
// rtpg_front
// Register file and raster position tracking; pushes one position per
// accepted input transfer into the queue.
// ----------------------------------------------------------------------------
module rtpg_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_restart,
  output logic                              in_ready,
  input  logic                              q_full,
  output logic                              q_push,
  output rtpg_pkg::rtpg_pos_t               q_data,
  output rtpg_pkg::rtpg_cfg_t               cfg
);
  import rtpg_pkg::*;

  logic [1:0]       kind_r;
  logic [DIM_W-1:0] width_r, height_r, tile_r;
  logic [CNT_W-1:0] nch_r;
  logic [31:0]      color_a_r, color_b_r;

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic             wrap;
  logic [POS_W-1:0] x, y;
  logic             eol, eof;

  always_comb begin
    cfg.kind    = kind_r;
    cfg.w       = clamp_dim(width_r);
    cfg.h       = clamp_dim(height_r);
    cfg.tile    = (tile_r == '0) ? DIM_W'(1) : tile_r;
    if (nch_r == '0) begin
      cfg.nch = CNT_W'(1);
    end else if (nch_r > CNT_W'(MAX_CHANNELS)) begin
      cfg.nch = CNT_W'(MAX_CHANNELS);
    end else begin
      cfg.nch = nch_r;
    end
    cfg.color_a = color_a_r;
    cfg.color_b = color_b_r;
  end

  assign in_ready = ~q_full;
  assign q_push   = in_valid & in_ready;

  always_comb begin
    // a shrunk frame can leave the counters outside it
    wrap = in_restart || ({1'b0, col_r} >= cfg.w) || ({1'b0, row_r} >= cfg.h);
    x    = wrap ? '0 : col_r;
    y    = wrap ? '0 : row_r;
    eol  = ({1'b0, x} == cfg.w - DIM_W'(1));
    eof  = eol && ({1'b0, y} == cfg.h - DIM_W'(1));
    if (eol) begin
      col_nxt = '0;
      row_nxt = eof ? '0 : y + POS_W'(1);
    end else begin
      col_nxt = x + POS_W'(1);
      row_nxt = y;
    end
    q_data.x   = x;
    q_data.y   = y;
    q_data.eol = eol;
    q_data.eof = eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_SOLID;
      width_r   <= DIM_W'(64);
      height_r  <= DIM_W'(64);
      nch_r     <= CNT_W'(3);
      tile_r    <= DIM_W'(8);
      color_a_r <= 32'h0000_0000;
      color_b_r <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KIND:   kind_r    <= cfg_wdata[1:0];
        REG_WIDTH:  width_r   <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: height_r  <= cfg_wdata[DIM_W-1:0];
        REG_NCH:    nch_r     <= cfg_wdata[CNT_W-1:0];
        REG_TILE:   tile_r    <= cfg_wdata[DIM_W-1:0];
        REG_COLORA: color_a_r <= cfg_wdata;
        REG_COLORB: color_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/rtpg_back.sv
// ----------------------------------------------------------------------------
// rtpg_back
// Pixel value engine: serial dividers for the gradient shades and the
// checker square parity, plus the output register.
// ----------------------------------------------------------------------------
module rtpg_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtpg_pkg::rtpg_cfg_t   cfg,
  input  logic                  q_empty,
  input  rtpg_pkg::rtpg_pos_t   q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [55:0]           out_data,
  output logic                  out_last,
  output logic                  out_user
);
  import rtpg_pkg::*;

  rtpg_bk_state_t state_r, state_nxt;

  rtpg_pos_t         pos_r;
  logic [CH_W-1:0]   ch_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  num_r;
  logic [6:0]        q_r;
  logic [7:0]        chan_r [MAX_CHANNELS];
  logic [POS_W-1:0]  xs_r, ys_r;
  logic [DIM_W-1:0]  remx_r, remy_r;
  logic              odd_r;

  logic              out_valid_r;
  logic [55:0]       out_data_r;
  logic              out_last_r, out_user_r;

  logic              out_free, load, grad_on, last_ch;
  logic [POS_W-1:0]  hm1;
  logic [NUM_W-1:0]  d_sh, prod_a, prod_b;
  logic [NUM_W:0]    num_sum;
  logic              ge;
  logic [DIM_W:0]    tx, ty;
  logic              gex, gey;
  logic [7:0]        pix [MAX_CHANNELS];

  assign out_free = ~out_valid_r | out_ready;
  assign grad_on  = (cfg.kind == KIND_GRAD) && (cfg.h != DIM_W'(1));
  assign hm1      = POS_W'(cfg.h - DIM_W'(1));
  assign last_ch  = ({1'b0, ch_r} == cfg.nch - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (grad_on) begin
            state_nxt = BK_MUL_A;
          end else if (cfg.kind == KIND_CHECK) begin
            state_nxt = BK_TILE;
          end else begin
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_MUL_A: state_nxt = BK_MUL_B;
      BK_MUL_B: state_nxt = BK_DIV;
      BK_DIV: begin
        if (step_r == '0) begin
          state_nxt = last_ch ? BK_EMIT : BK_MUL_A;
        end
      end
      BK_TILE: begin
        if (step_r == '0) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop = (state_r == BK_IDLE) && !q_empty;
    load  = (state_r == BK_EMIT) && out_free;
  end

  // datapath arithmetic
  always_comb begin
    prod_a  = NUM_W'(hm1 - pos_r.y) * NUM_W'(byte_of(cfg.color_a, ch_r));
    prod_b  = NUM_W'(pos_r.y) * NUM_W'(byte_of(cfg.color_b, ch_r));
    num_sum = {1'b0, num_r} + {1'b0, prod_b};
    // restoring division, quotient fits eight bits
    d_sh    = NUM_W'(hm1) << step_r[2:0];
    ge      = (num_r >= d_sh);
    tx      = {remx_r, xs_r[POS_W-1]};
    ty      = {remy_r, ys_r[POS_W-1]};
    gex     = (tx >= {1'b0, cfg.tile});
    gey     = (ty >= {1'b0, cfg.tile});
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (CNT_W'(c) >= cfg.nch) begin
        pix[c] = 8'h00;
      end else if (grad_on) begin
        pix[c] = chan_r[c];
      end else if (cfg.kind == KIND_CHECK && odd_r) begin
        pix[c] = byte_of(cfg.color_b, CH_W'(c));
      end else begin
        pix[c] = byte_of(cfg.color_a, CH_W'(c));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pos_r  <= q_data;
      ch_r   <= '0;
      odd_r  <= 1'b0;
      xs_r   <= q_data.x;
      ys_r   <= q_data.y;
      remx_r <= '0;
      remy_r <= '0;
      step_r <= STEP_W'(POS_W - 1);
    end
    unique case (state_r)
      BK_MUL_A: num_r <= prod_a;
      BK_MUL_B: begin
        num_r  <= num_sum[NUM_W-1:0];
        step_r <= STEP_W'(7);
      end
      BK_DIV: begin
        num_r  <= ge ? num_r - d_sh : num_r;
        q_r    <= {q_r[5:0], ge};
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          chan_r[ch_r] <= {q_r, ge};
          ch_r         <= ch_r + CH_W'(1);
        end
      end
      BK_TILE: begin
        remx_r <= gex ? DIM_W'(tx - {1'b0, cfg.tile}) : tx[DIM_W-1:0];
        remy_r <= gey ? DIM_W'(ty - {1'b0, cfg.tile}) : ty[DIM_W-1:0];
        xs_r   <= {xs_r[POS_W-2:0], 1'b0};
        ys_r   <= {ys_r[POS_W-2:0], 1'b0};
        step_r <= step_r - STEP_W'(1);
        // parity of the sum of both quotients is the xor of their lsbs
        if (step_r == '0) begin
          odd_r <= gex ^ gey;
        end
      end
      default: ;
    endcase
    if (load) begin
      out_data_r <= {pos_r.y, pos_r.x, pix[3], pix[2], pix[1], pix[0]};
      out_last_r <= pos_r.eol;
      out_user_r <= pos_r.eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_user  = out_user_r;

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (step_r < STEP_W'(8)))
    else $error("rtpg_back: shade divider ran past eight steps");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != BK_IDLE))
    else $error("rtpg_back: popped position not worked on");

endmodule
